/* rtl/ppc_bat_and_hashed_page_translate_core_assert.svh */
// ----------------------------------------------------------------------------
// ppc_bat_and_hashed_page_translate_core_assert.svh
// Assertion macros for the address translation core.
// ----------------------------------------------------------------------------
`ifndef PPC_BAT_AND_HASHED_PAGE_TRANSLATE_CORE_ASSERT_SVH
`define PPC_BAT_AND_HASHED_PAGE_TRANSLATE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPCBAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppcbat assertion failed");
`define PPCBAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppcbat assertion failed");
`else
`define PPCBAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PPCBAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ppcbat_pkg.sv */
// ----------------------------------------------------------------------------
// ppcbat_pkg
// Types, constants and helper functions for the address translation core.
// ----------------------------------------------------------------------------
package ppcbat_pkg;

  localparam int MEM_WORD_ADDR_BITS = 14;
  localparam int BAT_PAIRS          = 4;
  localparam int PTES_PER_GROUP     = 8;

  localparam int ROW_BITS    = MEM_WORD_ADDR_BITS - 1;
  localparam int GRP_IDX_W   = $clog2(PTES_PER_GROUP);
  localparam int WALK_IDX_W  = GRP_IDX_W + 1;
  localparam int DBAT_WORDS  = 8;

  typedef enum logic [1:0] {
    OP_TRANSLATE  = 2'd0,
    OP_WRITE_SR   = 2'd1,
    OP_WRITE_DBAT = 2'd2,
    OP_WRITE_MEM  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OC_BAT          = 3'd0,
    OC_REAL         = 3'd1,
    OC_PRIMARY      = 3'd2,
    OC_SECONDARY    = 3'd3,
    OC_DIRECT_STORE = 3'd4,
    OC_FAULT        = 3'd5,
    OC_WRITE_DONE   = 3'd6
  } outcome_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] effective_address;
    logic        data_translate;
    logic [3:0]  reg_index;
    logic [13:0] word_address;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic        translated;
    logic [31:0] physical_address;
    outcome_t    outcome;
  } out_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] pa;
  } bat_res_t;

  function automatic bat_res_t bat_lookup(input logic [DBAT_WORDS-1:0][31:0] dbat,
                                          input logic [31:0] ea);
    bat_res_t    res;
    logic [31:0] up;
    logic [31:0] lo;
    logic [31:0] keep;
    res = '0;
    for (int p = 0; p < BAT_PAIRS; p++) begin
      up   = dbat[2*p];
      lo   = dbat[2*p+1];
      keep = {4'b0, up[12:2], 17'h1FFFF};
      if (!res.hit && (up[1:0] != 2'b00) &&
          ((ea & ~keep) == ((up & 32'hFFFE0000) & ~keep))) begin
        res.hit = 1'b1;
        res.pa  = ((lo & 32'hFFFE0000) & ~keep) | (ea & keep);
      end
    end
    return res;
  endfunction

  // Physical byte address of PTE idx; idx msb selects the secondary hash.
  function automatic logic [31:0] pte_addr(input logic [31:0] sdr1,
                                           input logic [23:0] vsid,
                                           input logic [31:0] ea,
                                           input logic [WALK_IDX_W-1:0] idx);
    logic [18:0] hash;
    logic [31:0] base;
    hash = vsid[18:0] ^ {3'b0, ea[27:12]};
    if (idx[WALK_IDX_W-1]) begin
      hash = ~hash;
    end
    base = {sdr1[31:25], sdr1[24:16] | (hash[18:10] & sdr1[8:0]), hash[9:0], 6'b0};
    return base | {{(29-GRP_IDX_W){1'b0}}, idx[GRP_IDX_W-1:0], 3'b0};
  endfunction

endpackage

/* rtl/ppc_bat_and_hashed_page_translate_core.sv */
// ----------------------------------------------------------------------------
// ppc_bat_and_hashed_page_translate_core
// DBAT check and hashed page table walk for 32-bit effective addresses.
// ----------------------------------------------------------------------------
// After reset the core clears the page table store, one 64-bit row per cycle,
// and holds busy high meanwhile. An item is taken when start is high and busy
// is low. Register writes and translations that end in a BAT hit, real mode
// or a direct-store segment are latched into the item register, resolved in
// the execute state and returned from the output register. A table walk
// reads one PTE (a 64-bit row of the table memory) per cycle and stops at
// the first match, so a walked item ends at the first matching PTE or in a
// page fault after all sixteen PTEs. Each result appears on out_data for one
// cycle with out_valid and cannot be held off; busy drops in that cycle.
// ----------------------------------------------------------------------------
module ppc_bat_and_hashed_page_translate_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ppcbat_pkg::in_item_t in_data,
  output logic                 out_valid,
  output ppcbat_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);

  localparam int RB = ppcbat_pkg::ROW_BITS;
  localparam int WB = ppcbat_pkg::MEM_WORD_ADDR_BITS;
  localparam int IW = ppcbat_pkg::WALK_IDX_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_t;

  state_t                    state_r, state_nxt;
  ppcbat_pkg::in_item_t      item_r;
  logic [31:0]               cfg_r;
  logic [15:0][31:0]         seg_r;
  logic [ppcbat_pkg::DBAT_WORDS-1:0][31:0] dbat_r;
  logic [RB-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [IW:0]               iss_cnt_r, iss_cnt_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      rd_oor_r, rd_oor_nxt;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [23:0]               vsid_r, vsid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ppcbat_pkg::out_item_t     out_data_r, out_data_nxt;

  logic                      seg_we, dbat_we;
  logic                      mem_we_even, mem_we_odd;
  logic [RB-1:0]             mem_waddr, mem_raddr;
  logic [31:0]               mem_wdata;
  logic [31:0]               rd_even, rd_odd;
  logic [31:0]               wa_ext;
  logic                      wa_ok;
  logic [31:0]               srv;
  logic [31:0]               pte_pa;
  ppcbat_pkg::bat_res_t      bat;
  logic                      pte_hit;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wa_ext = {18'b0, item_r.word_address};
  assign wa_ok  = (wa_ext[31:WB] == '0);
  assign srv    = seg_r[item_r.effective_address[31:28]];
  assign bat    = ppcbat_pkg::bat_lookup(dbat_r, item_r.effective_address);
  assign pte_pa = ppcbat_pkg::pte_addr(cfg_r, vsid_r, item_r.effective_address,
                                       iss_cnt_r[IW-1:0]);
  assign mem_raddr = pte_pa[RB+2:3];

  assign pte_hit = rd_vld_r && !rd_oor_r && rd_even[31] && (rd_even[30:7] == vsid_r) &&
                   (rd_even[6] == rd_idx_r[IW-1]) &&
                   (rd_even[5:0] == item_r.effective_address[27:22]);

  ppcbat_table_mem u_mem (
    .clk        (clk),
    .we_even    (mem_we_even),
    .we_odd     (mem_we_odd),
    .waddr      (mem_waddr),
    .wdata      (mem_wdata),
    .raddr      (mem_raddr),
    .rdata_even (rd_even),
    .rdata_odd  (rd_odd)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    iss_cnt_nxt   = iss_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_oor_nxt    = rd_oor_r;
    rd_idx_nxt    = rd_idx_r;
    vsid_nxt      = vsid_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    seg_we        = 1'b0;
    dbat_we       = 1'b0;
    mem_we_even   = 1'b0;
    mem_we_odd    = 1'b0;
    mem_waddr     = wa_ext[RB:1];
    mem_wdata     = item_r.write_value;
    case (state_r)
      ST_CLEAR: begin
        mem_we_even = 1'b1;
        mem_we_odd  = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_data_nxt = '{translated: 1'b0, physical_address: 32'd0,
                         outcome: ppcbat_pkg::OC_WRITE_DONE};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        case (item_r.operation)
          ppcbat_pkg::OP_WRITE_SR: begin
            seg_we = 1'b1;
          end
          ppcbat_pkg::OP_WRITE_DBAT: begin
            dbat_we = ({1'b0, item_r.reg_index} < 5'(2 * ppcbat_pkg::BAT_PAIRS));
          end
          ppcbat_pkg::OP_WRITE_MEM: begin
            mem_we_even = wa_ok && !item_r.word_address[0];
            mem_we_odd  = wa_ok && item_r.word_address[0];
          end
          default: begin
            if (bat.hit) begin
              out_data_nxt = '{translated: 1'b1, physical_address: bat.pa,
                               outcome: ppcbat_pkg::OC_BAT};
            end else if (!item_r.data_translate) begin
              out_data_nxt = '{translated: 1'b1,
                               physical_address: item_r.effective_address,
                               outcome: ppcbat_pkg::OC_REAL};
            end else if (srv[31]) begin
              out_data_nxt.outcome = ppcbat_pkg::OC_DIRECT_STORE;
            end else begin
              out_valid_nxt = 1'b0;
              vsid_nxt      = srv[23:0];
              iss_cnt_nxt   = '0;
              state_nxt     = ST_WALK;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (!iss_cnt_r[IW]) begin
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = iss_cnt_r[IW-1:0];
          rd_oor_nxt  = (pte_pa[31:WB+2] != '0);
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (pte_hit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{translated: 1'b1,
                            physical_address: {rd_odd[31:12],
                                               item_r.effective_address[11:0]},
                            outcome: rd_idx_r[IW-1] ? ppcbat_pkg::OC_SECONDARY
                                                    : ppcbat_pkg::OC_PRIMARY};
          state_nxt     = ST_IDLE;
        end else if (rd_vld_r && (rd_idx_r == '1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{translated: 1'b0, physical_address: 32'd0,
                            outcome: ppcbat_pkg::OC_FAULT};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      iss_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      cfg_r       <= '0;
      seg_r       <= '0;
      dbat_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (seg_we) begin
        seg_r[item_r.reg_index] <= item_r.write_value;
      end
      if (dbat_we) begin
        dbat_r[item_r.reg_index[2:0]] <= item_r.write_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      item_r <= in_data;
    end
    rd_oor_r   <= rd_oor_nxt;
    rd_idx_r   <= rd_idx_nxt;
    vsid_r     <= vsid_nxt;
  end

  `include "ppc_bat_and_hashed_page_translate_core_assert.svh"

  `PPCBAT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PPCBAT_ASSERT_IMPL(a_result_after_work, clk, rst_n, out_valid, $past(busy) && !busy)
  `PPCBAT_ASSERT_IMPL(a_fault_zero_pa, clk, rst_n, out_valid && !out_data.translated, out_data.physical_address == 32'd0)
  `PPCBAT_ASSERT_IMPL(a_walk_no_write, clk, rst_n, state_r == ST_WALK, !mem_we_even && !mem_we_odd)

endmodule

/* rtl/ppcbat_table_mem.sv */
// ----------------------------------------------------------------------------
// ppcbat_table_mem
// Page table store: even and odd words side by side, one 64-bit row read
// per cycle with registered read data, independent word writes.
// ----------------------------------------------------------------------------
module ppcbat_table_mem (
  input  logic                          clk,
  input  logic                          we_even,
  input  logic                          we_odd,
  input  logic [ppcbat_pkg::ROW_BITS-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic [ppcbat_pkg::ROW_BITS-1:0] raddr,
  output logic [31:0]                   rdata_even,
  output logic [31:0]                   rdata_odd
);

  localparam int ROWS = 1 << ppcbat_pkg::ROW_BITS;

  logic [31:0] mem_even [ROWS];
  logic [31:0] mem_odd  [ROWS];

  always_ff @(posedge clk) begin
    if (we_even) begin
      mem_even[waddr] <= wdata;
    end
    rdata_even <= mem_even[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      mem_odd[waddr] <= wdata;
    end
    rdata_odd <= mem_odd[raddr];
  end

endmodule

/* tb/sv/tb_ppc_bat_and_hashed_page_translate_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppc_bat_and_hashed_page_translate_core
// Self-checking bench for the DBAT / hashed page table translation core.
// A short table of directed transfers runs first. It is followed by random
// scenarios: segment setup, PTE install and lookup, BAT hit and miss,
// direct-store and real mode, plus raw noise. The table config is switched
// between phases. Results are checked against a predictor or a typed row.
// ----------------------------------------------------------------------------
module tb_ppc_bat_and_hashed_page_translate_core;
  import ppcbat_pkg::*;

  localparam int MEM_WORDS   = 1 << MEM_WORD_ADDR_BITS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES  = 5;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // predictor state
  bit [31:0] tbl_cfg;
  bit [31:0] seg_file  [16];
  bit [31:0] dbat_file [DBAT_WORDS];
  bit [31:0] page_mem  [MEM_WORDS];

  out_item_t   expected_xlat [$];
  logic [31:0] mapped_ea [$];
  dir_row_t    dir_rows [$];
  int          errors = 0;
  int          xfers_sent = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  ppc_bat_and_hashed_page_translate_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] group_base(logic [23:0] vsid, logic [31:0] ea, logic sec);
    logic [18:0] h;
    logic [8:0]  hi;
    h = vsid[18:0] ^ {3'b000, ea[27:12]};
    if (sec) begin
      h = ~h;
    end
    hi = tbl_cfg[24:16] | (h[18:10] & tbl_cfg[8:0]);
    return {tbl_cfg[31:25], hi, h[9:0], 6'b000000};
  endfunction

  function automatic logic [31:0] read_pte_word(logic [31:0] addr);
    if ((addr >> 2) < MEM_WORDS) begin
      return page_mem[addr >> 2];
    end
    return 32'h0;
  endfunction

  function automatic out_item_t predict_translation(in_item_t it);
    out_item_t   r;
    logic [31:0] up, lo, keep, srv, w0, w1, base, ea;
    logic [23:0] vsid;
    logic        found;
    ea = it.effective_address;
    r.translated       = 1'b0;
    r.physical_address = 32'h0;
    r.outcome          = OC_WRITE_DONE;
    case (it.operation)
      OP_WRITE_SR: begin
        seg_file[it.reg_index] = it.write_value;
      end
      OP_WRITE_DBAT: begin
        if (it.reg_index < 2 * BAT_PAIRS) begin
          dbat_file[it.reg_index[2:0]] = it.write_value;
        end
      end
      OP_WRITE_MEM: begin
        if (it.word_address < MEM_WORDS) begin
          page_mem[it.word_address] = it.write_value;
        end
      end
      default: begin
        found = 1'b0;
        for (int p = 0; p < BAT_PAIRS; p++) begin
          up   = dbat_file[2*p];
          lo   = dbat_file[2*p+1];
          keep = (((up >> 2) & 32'h7FF) << 17) | 32'h1FFFF;
          if (!found && up[1:0] != 2'b00 &&
              (ea & ~keep) == (up & 32'hFFFE0000 & ~keep)) begin
            found              = 1'b1;
            r.translated       = 1'b1;
            r.physical_address = (lo & 32'hFFFE0000 & ~keep) | (ea & keep);
            r.outcome          = OC_BAT;
          end
        end
        if (!found && !it.data_translate) begin
          r.translated       = 1'b1;
          r.physical_address = ea;
          r.outcome          = OC_REAL;
        end else if (!found) begin
          srv = seg_file[ea[31:28]];
          if (srv[31]) begin
            r.outcome = OC_DIRECT_STORE;
          end else begin
            vsid      = srv[23:0];
            r.outcome = OC_FAULT;
            for (int s = 0; s < 2; s++) begin
              base = group_base(vsid, ea, s[0]);
              for (int i = 0; i < PTES_PER_GROUP; i++) begin
                w0 = read_pte_word(base + 32'(i * 8));
                w1 = read_pte_word(base + 32'(i * 8 + 4));
                if (!found && w0[31] && w0[30:7] == vsid && w0[6] == s[0] &&
                    w0[5:0] == ea[27:22]) begin
                  found              = 1'b1;
                  r.translated       = 1'b1;
                  r.physical_address = {w1[31:12], ea[11:0]};
                  r.outcome          = s[0] ? OC_SECONDARY : OC_PRIMARY;
                end
              end
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation         = op_t'($urandom_range(0, 3));
    it.effective_address = $urandom;
    it.data_translate    = 1'($urandom);
    it.reg_index         = 4'($urandom);
    it.word_address      = 14'($urandom);
    it.write_value       = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_item(op_t op, logic [31:0] ea, logic dr, logic [3:0] ri,
                                       logic [13:0] wa, logic [31:0] wv);
    in_item_t it;
    it.operation         = op;
    it.effective_address = ea;
    it.data_translate    = dr;
    it.reg_index         = ri;
    it.word_address      = wa;
    it.write_value       = wv;
    return it;
  endfunction

  function automatic out_item_t xlat_res(logic ok, logic [31:0] pa, outcome_t oc);
    out_item_t r;
    r.translated       = ok;
    r.physical_address = pa;
    r.outcome          = oc;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // start is left high after a transfer; only a gap lowers it
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    pred = predict_translation(it);
    expected_xlat.push_back(typed ? want : pred);
    xfers_sent++;
  endtask

  task automatic xlate(input logic [31:0] ea, input logic dr);
    in_item_t it;
    it                   = rand_item();
    it.operation         = OP_TRANSLATE;
    it.effective_address = ea;
    it.data_translate    = dr;
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_reg(input op_t op, input logic [3:0] idx, input logic [31:0] v);
    in_item_t it;
    it             = rand_item();
    it.operation   = op;
    it.reg_index   = idx;
    it.write_value = v;
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_word(input logic [31:0] byte_addr, input logic [31:0] v);
    in_item_t it;
    it              = rand_item();
    it.operation    = OP_WRITE_MEM;
    it.word_address = 14'(byte_addr >> 2);
    it.write_value  = v;
    send_item(it, 1'b0, '0);
  endtask

  // program a segment, install a PTE in its group, then look it up
  task automatic map_and_translate();
    logic [31:0] ea, pte_at, w0;
    logic [23:0] vsid;
    logic        sec;
    int          slot;
    ea   = $urandom;
    vsid = 24'($urandom);
    sec  = ($urandom_range(0, 2) == 0);
    slot = $urandom_range(0, PTES_PER_GROUP - 1);
    if (tbl_cfg[8:0] != 9'h0 && $urandom_range(0, 3) != 0) begin
      vsid[18:10] = {3'b000, ea[27:22]} ^ {9{sec}};
    end
    write_reg(OP_WRITE_SR, ea[31:28], {1'b0, 7'($urandom), vsid});
    pte_at = group_base(vsid, ea, sec) + 32'(slot * 8);
    w0     = {1'b1, vsid, sec, ea[27:22]};
    if ((pte_at >> 2) < MEM_WORDS) begin
      if (slot != 0 && $urandom_range(0, 2) == 0) begin
        write_word(pte_at - 8,
                   $urandom_range(0, 1) ? w0 : w0 ^ (32'h1 << $urandom_range(0, 31)));
        write_word(pte_at - 4, $urandom);
      end
      write_word(pte_at, w0);
      write_word(pte_at + 4, $urandom);
    end
    xlate(ea, $urandom_range(0, 7) != 0);
    if ($urandom_range(0, 1) == 1) begin
      xlate({ea[31:12], 12'($urandom)}, 1'b1);
    end
    mapped_ea.push_back(ea);
    if (mapped_ea.size() > 16) begin
      void'(mapped_ea.pop_front());
    end
  endtask

  task automatic bat_scenario();
    logic [31:0] ea;
    logic [10:0] bl;
    int          p;
    ea = $urandom;
    p  = $urandom_range(0, BAT_PAIRS - 1);
    bl = 11'h7FF >> $urandom_range(0, 11);
    write_reg(OP_WRITE_DBAT, 4'(2 * p), {ea[31:17], 4'($urandom), bl, 2'($urandom_range(1, 3))});
    write_reg(OP_WRITE_DBAT, 4'(2 * p + 1), $urandom);
    xlate(ea ^ (32'($urandom) & {4'h0, bl, 17'h1FFFF}), 1'($urandom));
    xlate($urandom, 1'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      write_reg(OP_WRITE_DBAT, 4'(2 * p), {30'($urandom), 2'b00});
    end
  endtask

  task automatic write_table_cfg(input logic [31:0] v);
    start <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    tbl_cfg = v;
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid) begin
      if (expected_xlat.size() == 0) begin
        errors++;
        $display("%0t: unexpected result exp none got %h", $time, out_data);
      end else begin
        exp_item = expected_xlat.pop_front();
        if (out_data.translated !== exp_item.translated) begin
          errors++;
          $display("%0t: translated exp %0b got %0b", $time,
                   exp_item.translated, out_data.translated);
        end
        if (out_data.physical_address !== exp_item.physical_address) begin
          errors++;
          $display("%0t: physical_address exp %h got %h", $time,
                   exp_item.physical_address, out_data.physical_address);
        end
        if (out_data.outcome !== exp_item.outcome) begin
          errors++;
          $display("%0t: outcome exp %0d got %0d", $time,
                   exp_item.outcome, out_data.outcome);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ppc_bat_and_hashed_page_translate_core: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_cfg [NUM_PHASES];
    int          phase_len [NUM_PHASES];
    logic [31:0] a_ea, b_ea, a_pte, b_pte;
    int          goal, pick;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 32'h0;
    tbl_cfg   = 32'h0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    a_ea  = 32'h1ABC_D123;
    b_ea  = 32'h2FFF_F000;
    a_pte = group_base(24'hABCDEF, a_ea, 1'b0) + 32'd56;
    b_pte = group_base(24'h000000, b_ea, 1'b1);

    add_row(mk_item(OP_TRANSLATE, 32'h0, 1'b0, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b1, 32'h0, OC_REAL));
    add_row(mk_item(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b0, 4'hF, 14'h3FFF, 32'hFFFF_FFFF), 1'b1,
            xlat_res(1'b1, 32'hFFFF_FFFF, OC_REAL));
    add_row(mk_item(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b0, 32'h0, OC_FAULT));
    add_row(mk_item(OP_WRITE_SR, 32'h0, 1'b0, 4'hF, 14'h0, 32'h8000_0000), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_TRANSLATE, 32'hF000_0000, 1'b1, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b0, 32'h0, OC_DIRECT_STORE));
    // DBAT index past the last pair is dropped
    add_row(mk_item(OP_WRITE_DBAT, 32'h0, 1'b0, 4'hF, 14'h0, 32'hFFFF_FFFF), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'h3FFF, 32'hFFFF_FFFF), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_WRITE_DBAT, 32'h0, 1'b0, 4'h0, 14'h0, 32'h0000_1FFF), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_WRITE_DBAT, 32'h0, 1'b0, 4'h1, 14'h0, 32'hFFFE_0000), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_TRANSLATE, 32'h0FFF_FFFF, 1'b1, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b1, 32'hFFFF_FFFF, OC_BAT));
    add_row(mk_item(OP_TRANSLATE, 32'h1000_0000, 1'b0, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b1, 32'h1000_0000, OC_REAL));
    add_row(mk_item(OP_WRITE_DBAT, 32'h0, 1'b0, 4'h6, 14'h0, 32'hFFFE_0003), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_WRITE_DBAT, 32'h0, 1'b0, 4'h7, 14'h0, 32'h0002_0000), 1'b1,
            xlat_res(1'b0, 32'h0, OC_WRITE_DONE));
    add_row(mk_item(OP_TRANSLATE, 32'hFFFE_1234, 1'b1, 4'h0, 14'h0, 32'h0), 1'b1,
            xlat_res(1'b1, 32'h0002_1234, OC_BAT));
    // primary hit in the last slot, secondary hit in the first slot
    add_row(mk_item(OP_WRITE_SR, 32'h0, 1'b0, 4'h1, 14'h0, 32'h00AB_CDEF), 1'b0, '0);
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'(a_pte >> 2),
                    {1'b1, 24'hABCDEF, 1'b0, a_ea[27:22]}), 1'b0, '0);
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'((a_pte + 4) >> 2),
                    32'h1234_5FFF), 1'b0, '0);
    add_row(mk_item(OP_TRANSLATE, a_ea, 1'b1, 4'h0, 14'h0, 32'h0), 1'b0, '0);
    add_row(mk_item(OP_WRITE_SR, 32'h0, 1'b0, 4'h2, 14'h0, 32'h7F00_0000), 1'b0, '0);
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'(b_pte >> 2),
                    {1'b1, 24'h000000, 1'b1, b_ea[27:22]}), 1'b0, '0);
    add_row(mk_item(OP_WRITE_MEM, 32'h0, 1'b0, 4'h0, 14'((b_pte + 4) >> 2),
                    32'hFFFF_F000), 1'b0, '0);
    add_row(mk_item(OP_TRANSLATE, b_ea, 1'b1, 4'h0, 14'h0, 32'h0), 1'b0, '0);
    add_row(mk_item(OP_TRANSLATE, 32'h1ABC_E123, 1'b1, 4'h0, 14'h0, 32'h0), 1'b0, '0);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    phase_cfg[0] = 32'h0000_01FF;
    phase_cfg[1] = 32'hFFFF_FFFF;
    phase_cfg[2] = $urandom;
    phase_cfg[3] = {23'h0, 9'($urandom)};
    phase_cfg[4] = 32'h0000_0000;
    phase_len[0] = 200;
    phase_len[1] = 100;
    phase_len[2] = 100;
    phase_len[3] = 250;
    phase_len[4] = 600;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_table_cfg(phase_cfg[ph]);
      goal = xfers_sent + phase_len[ph];
      while (xfers_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          map_and_translate();
        end else if (pick < 55) begin
          bat_scenario();
        end else if (pick < 65) begin
          a_ea = $urandom;
          write_reg(OP_WRITE_SR, a_ea[31:28], {($urandom_range(0, 3) != 0), 31'($urandom)});
          xlate(a_ea, 1'($urandom));
        end else if (pick < 80 && mapped_ea.size() != 0) begin
          xlate(mapped_ea[$urandom_range(0, mapped_ea.size() - 1)], 1'b1);
        end else begin
          a_ea = $urandom;
          dir_rows[0].item = rand_item();
          if (dir_rows[0].item.operation == OP_WRITE_DBAT && !dir_rows[0].item.reg_index[0] &&
              $urandom_range(0, 2) != 0) begin
            dir_rows[0].item.write_value[1:0] = 2'b00;
          end
          send_item(dir_rows[0].item, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ppc_bat_and_hashed_page_translate_core: done, clean");
    end else begin
      $display("tb_ppc_bat_and_hashed_page_translate_core: done, errors");
    end
    $finish;
  end

endmodule
